/* design/assert_macros.svh */
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define PSRF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, held off during reset
`define PSRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* design/psrf_pkg.sv */
// ----------------------------------------------------------------------------
// psrf_pkg
// Types, constants and helper functions of the pointing-stick report filter.
// ----------------------------------------------------------------------------
package psrf_pkg;

	localparam int unsigned SCROLL_DIV_DEFAULT = 1;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam int unsigned DIV_W     = 32;
	localparam int unsigned DVS_W     = 16;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

	localparam logic [2:0] MIDDLE_MASK = 3'b100;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEADZONE = 3'd0,
		CFG_PTR_MULT_X = 3'd1,
		CFG_PTR_MULT_Y = 3'd2,
		CFG_PTR_DIV_X = 3'd3,
		CFG_PTR_DIV_Y = 3'd4,
		CFG_SCR_MULT_V = 3'd5,
		CFG_SCR_MULT_H = 3'd6,
		CFG_SPARE = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_PRESSED = 2'd1,
		MODE_SCROLLED = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_MUL,
		SEQ_DIV,
		SEQ_CLICK,
		SEQ_EMIT
	} seq_t;

	typedef struct packed {
		logic             start;
		logic             neg;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [DIV_W-1:0] quotient;
	} div_rsp_t;

	// move a delta toward zero by the deadzone magnitude
	function automatic logic signed [15:0] shrink(input logic signed [15:0] d,
		input logic [14:0] dz);
		logic signed [16:0] de;
		logic signed [16:0] dze;
		logic signed [16:0] r;
		de  = 17'(d);
		dze = $signed({2'b00, dz});
		if (de > dze) begin
			r = de - dze;
		end else if (de < -dze) begin
			r = de + dze;
		end else begin
			r = '0;
		end
		return r[15:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
		logic signed [15:0] r;
		if (v > 32'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -32'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

/* design/psrf_if.sv */
// ----------------------------------------------------------------------------
// psrf_if
// Valid/ready channels for reports in and filtered events out.
// ----------------------------------------------------------------------------
interface psrf_report_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] delta_x;
	logic signed [15:0] delta_y;
	logic [2:0]         button_bits;
	logic [63:0]        stamp;

	modport source (output valid, output delta_x, output delta_y,
		output button_bits, output stamp, input ready);
	modport sink (input valid, input delta_x, input delta_y,
		input button_bits, input stamp, output ready);
endinterface

interface psrf_result_if;
	logic               valid;
	logic               ready;
	logic               event_kind;
	logic signed [31:0] move_x;
	logic signed [31:0] move_y;
	logic signed [15:0] scroll_v;
	logic signed [15:0] scroll_h;
	logic [2:0]         button_out;
	logic [63:0]        stamp_out;
	logic               last;

	modport source (output valid, output event_kind, output move_x, output move_y,
		output scroll_v, output scroll_h, output button_out, output stamp_out,
		output last, input ready);
	modport sink (input valid, input event_kind, input move_x, input move_y,
		input scroll_v, input scroll_h, input button_out, input stamp_out,
		input last, output ready);
endinterface

/* design/psrf_div.sv */
// ----------------------------------------------------------------------------
// psrf_div
// Restoring divider, one quotient bit per cycle, sign applied at the end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psrf_div (
	input  logic                clk,
	input  logic                arst_n,
	input  psrf_pkg::div_req_t  req,
	output psrf_pkg::div_rsp_t  rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [psrf_pkg::DIV_CNT_W-1:0]      cnt_q;
	logic [psrf_pkg::DVS_W-1:0]          rem_q;
	logic [psrf_pkg::DIV_W-1:0]          quo_q;
	logic [psrf_pkg::DVS_W-1:0]          dvs_q;
	logic                                neg_q;

	logic [psrf_pkg::DVS_W:0] trial;
	logic [psrf_pkg::DVS_W:0] diff;
	logic                     fits;

	assign trial = {rem_q, quo_q[psrf_pkg::DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == psrf_pkg::DIV_CNT_W'(psrf_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
			neg_q <= req.neg;
		end else if (busy_q) begin
			rem_q <= fits ? diff[psrf_pkg::DVS_W-1:0] : trial[psrf_pkg::DVS_W-1:0];
			quo_q <= {quo_q[psrf_pkg::DIV_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

	// partial remainder always stays below the divisor
	`PSRF_ASSERT_IMPLIES(a_rem_below_divisor, clk, arst_n, busy_q && !req.start, rem_q < dvs_q)

endmodule

/* design/pointing_stick_report_filter.sv */
// ----------------------------------------------------------------------------
// pointing_stick_report_filter
// Deadzone, middle-button scroll emulation and gain scaling of stick reports.
// ----------------------------------------------------------------------------
// Reports come in on the report channel (valid/ready): signed deltas, button
// bits and a timestamp. Events leave on the result channel: a pointer move or
// a scroll event, last set on the final event of a report. A middle click
// with no motion in between gives an extra pointer event (middle bit only,
// unscaled deltas, last clear) ahead of the normal one.
// One report is worked on at a time; ready is high only between reports.
// Each axis is a 16x16 multiply, a 32-step serial divide in the
// shared divider and a step to collect the quotient; X goes first,
// then Y, and the events are loaded once both quotients are in. The
// next report is taken only after the final event has been loaded.
// The result register holds an event until it is taken; while the receiver
// stalls the sequencer waits and no new report is taken.
// Reset (arst_n low) returns the config registers to defaults, puts the
// middle button tracker in idle and drops any work under way.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once; the
// user must make them only between reports. The block does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pointing_stick_report_filter #(
	parameter int unsigned SCROLL_DIV_V = psrf_pkg::SCROLL_DIV_DEFAULT,
	parameter int unsigned SCROLL_DIV_H = psrf_pkg::SCROLL_DIV_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [psrf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psrf_pkg::CFG_DATA_W-1:0] cfg_data,
	psrf_report_if.sink                     report,
	psrf_result_if.source                   result
);

	localparam logic [15:0] SDIV_V = (SCROLL_DIV_V == 0) ? 16'd1 : 16'(SCROLL_DIV_V);
	localparam logic [15:0] SDIV_H = (SCROLL_DIV_H == 0) ? 16'd1 : 16'(SCROLL_DIV_H);

	// configuration
	logic [14:0] deadzone_q;
	logic [15:0] pmx_q, pmy_q, pdx_q, pdy_q;
	logic [14:0] smv_q, smh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q <= '0;
			pmx_q      <= 16'd1;
			pmy_q      <= 16'd1;
			pdx_q      <= 16'd1;
			pdy_q      <= 16'd1;
			smv_q      <= 15'd1;
			smh_q      <= 15'd1;
		end else if (cfg_we) begin
			case (psrf_pkg::cfg_reg_t'(cfg_index))
				psrf_pkg::CFG_DEADZONE:   deadzone_q <= cfg_data[14:0];
				psrf_pkg::CFG_PTR_MULT_X: pmx_q <= cfg_data;
				psrf_pkg::CFG_PTR_MULT_Y: pmy_q <= cfg_data;
				psrf_pkg::CFG_PTR_DIV_X:  pdx_q <= cfg_data;
				psrf_pkg::CFG_PTR_DIV_Y:  pdy_q <= cfg_data;
				psrf_pkg::CFG_SCR_MULT_V: smv_q <= cfg_data[14:0];
				psrf_pkg::CFG_SCR_MULT_H: smh_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// sequencer state and report context
	psrf_pkg::seq_t  state_q, state_d;
	psrf_pkg::mode_t mode_q, mode_d;
	logic            axis_q;
	logic            click_q, click_d;
	logic            scroll_q;
	logic signed [15:0] dx_q, dy_q;
	logic [2:0]         btn_q;
	logic [63:0]        stamp_q;
	logic signed [31:0] qx_q, qy_q;

	logic signed [15:0] dx_sh, dy_sh;
	logic               released, moving, take;

	assign dx_sh    = psrf_pkg::shrink(report.delta_x, deadzone_q);
	assign dy_sh    = psrf_pkg::shrink(report.delta_y, deadzone_q);
	assign released = (report.button_bits & psrf_pkg::MIDDLE_MASK) == 3'b000;
	assign moving   = (dx_sh != 16'sd0) || (dy_sh != 16'sd0);
	assign take     = report.valid && report.ready;

	// middle button tracker
	always_comb begin
		mode_d  = psrf_pkg::MODE_IDLE;
		click_d = 1'b0;
		case (mode_q)
			psrf_pkg::MODE_SCROLLED: begin
				mode_d = released ? psrf_pkg::MODE_IDLE : psrf_pkg::MODE_SCROLLED;
			end
			psrf_pkg::MODE_PRESSED: begin
				click_d = released;
				if (released) mode_d = psrf_pkg::MODE_IDLE;
				else if (moving) mode_d = psrf_pkg::MODE_SCROLLED;
				else mode_d = psrf_pkg::MODE_PRESSED;
			end
			default: begin
				if (!released) begin
					mode_d = moving ? psrf_pkg::MODE_SCROLLED : psrf_pkg::MODE_PRESSED;
				end
			end
		endcase
	end

	// shared multiply feeding the divider
	logic signed [15:0] sel_d;
	logic [15:0]        sel_mult, sel_div, mag;
	logic               out_free, load_click, load_main;
	psrf_pkg::div_req_t div_req;
	psrf_pkg::div_rsp_t div_rsp;

	always_comb begin
		sel_d = axis_q ? dy_q : dx_q;
		if (scroll_q) begin
			sel_mult = axis_q ? {1'b0, smv_q} : {1'b0, smh_q};
			sel_div  = axis_q ? SDIV_V : SDIV_H;
		end else begin
			sel_mult = axis_q ? pmy_q : pmx_q;
			sel_div  = axis_q ? pdy_q : pdx_q;
		end
		mag = sel_d[15] ? 16'(-sel_d) : 16'(sel_d);
	end

	psrf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			psrf_pkg::SEQ_IDLE:  if (report.valid) state_d = psrf_pkg::SEQ_MUL;
			psrf_pkg::SEQ_MUL:   state_d = psrf_pkg::SEQ_DIV;
			psrf_pkg::SEQ_DIV: begin
				if (div_rsp.done) begin
					if (!axis_q) state_d = psrf_pkg::SEQ_MUL;
					else state_d = click_q ? psrf_pkg::SEQ_CLICK : psrf_pkg::SEQ_EMIT;
				end
			end
			psrf_pkg::SEQ_CLICK: if (out_free) state_d = psrf_pkg::SEQ_EMIT;
			psrf_pkg::SEQ_EMIT:  if (out_free) state_d = psrf_pkg::SEQ_IDLE;
			default:             state_d = psrf_pkg::SEQ_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		div_req.start    = 1'b0;
		div_req.neg      = sel_d[15];
		div_req.dividend = 32'(mag) * 32'(sel_mult);
		div_req.divisor  = (sel_div == 16'd0) ? 16'd1 : sel_div;
		load_click       = 1'b0;
		load_main        = 1'b0;
		case (state_q)
			psrf_pkg::SEQ_MUL:   div_req.start = 1'b1;
			psrf_pkg::SEQ_CLICK: load_click = out_free;
			psrf_pkg::SEQ_EMIT:  load_main = out_free;
			default: ;
		endcase
	end

	assign report.ready = state_q == psrf_pkg::SEQ_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psrf_pkg::SEQ_IDLE;
			mode_q  <= psrf_pkg::MODE_IDLE;
			axis_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				mode_q <= mode_d;
				axis_q <= 1'b0;
			end else if (state_q == psrf_pkg::SEQ_DIV && div_rsp.done) begin
				axis_q <= ~axis_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			dx_q     <= dx_sh;
			dy_q     <= dy_sh;
			btn_q    <= report.button_bits & ~psrf_pkg::MIDDLE_MASK;
			stamp_q  <= report.stamp;
			click_q  <= click_d;
			scroll_q <= mode_d == psrf_pkg::MODE_SCROLLED;
		end
		if (state_q == psrf_pkg::SEQ_DIV && div_rsp.done) begin
			if (axis_q) qy_q <= div_rsp.quotient;
			else qx_q <= div_rsp.quotient;
		end
	end

	// result register
	logic               res_valid_q;
	logic               res_kind_q;
	logic signed [31:0] res_mx_q, res_my_q;
	logic signed [15:0] res_sv_q, res_sh_q;
	logic [2:0]         res_btn_q;
	logic [63:0]        res_stamp_q;
	logic               res_last_q;

	assign out_free = !res_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_click || load_main) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_click) begin
			res_kind_q  <= 1'b0;
			res_mx_q    <= 32'(dx_q);
			res_my_q    <= 32'(dy_q);
			res_sv_q    <= '0;
			res_sh_q    <= '0;
			res_btn_q   <= psrf_pkg::MIDDLE_MASK;
			res_stamp_q <= stamp_q;
			res_last_q  <= 1'b0;
		end else if (load_main) begin
			res_stamp_q <= stamp_q;
			res_last_q  <= 1'b1;
			if (scroll_q) begin
				res_kind_q <= 1'b1;
				res_mx_q   <= '0;
				res_my_q   <= '0;
				res_sv_q   <= psrf_pkg::sat16(qy_q);
				res_sh_q   <= psrf_pkg::sat16(qx_q);
				res_btn_q  <= '0;
			end else begin
				res_kind_q <= 1'b0;
				res_mx_q   <= qx_q;
				res_my_q   <= qy_q;
				res_sv_q   <= '0;
				res_sh_q   <= '0;
				res_btn_q  <= btn_q;
			end
		end
	end

	assign result.valid      = res_valid_q;
	assign result.event_kind = res_kind_q;
	assign result.move_x     = res_mx_q;
	assign result.move_y     = res_my_q;
	assign result.scroll_v   = res_sv_q;
	assign result.scroll_h   = res_sh_q;
	assign result.button_out = res_btn_q;
	assign result.stamp_out  = res_stamp_q;
	assign result.last       = res_last_q;

	// a non-final event can only be the middle click
	`PSRF_ASSERT_IMPLIES(a_click_event_form, clk, arst_n, result.valid && !result.last, result.event_kind == 1'b0 && result.button_out == psrf_pkg::MIDDLE_MASK)
	// divider answers only while the sequencer waits for it
	`PSRF_ASSERT_IMPLIES(a_div_done_in_div, clk, arst_n, div_rsp.done, state_q == psrf_pkg::SEQ_DIV)
	// scroll output only while the tracker is in the scrolled state
	`PSRF_ASSERT_IMPLIES(a_scroll_mode, clk, arst_n, load_main && scroll_q, mode_q == psrf_pkg::MODE_SCROLLED)

endmodule

/* test/pointing_stick_report_filter_tb.sv */
// ----------------------------------------------------------------------------
// pointing_stick_report_filter_tb
// Self-checking bench for the pointing-stick report filter.
// ----------------------------------------------------------------------------
// Reports go in on the report channel and every event that comes out is
// compared field by field with a local prediction of deadzone, middle-button
// tracking, click insertion, scroll saturation and pointer gain. Directed
// cases cover the field extremes and the click and scroll paths. Random
// gestures follow under several register settings and handshake stall
// patterns on both channels.
// ----------------------------------------------------------------------------
module pointing_stick_report_filter_tb;

	localparam int unsigned SCR_DIV_V  = psrf_pkg::SCROLL_DIV_DEFAULT;
	localparam int unsigned SCR_DIV_H  = psrf_pkg::SCROLL_DIV_DEFAULT;
	localparam int          IDLE_LIMIT = 4000;
	localparam int          RAND_ITEMS = 150;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] mx;
		logic signed [31:0] my;
		logic signed [15:0] sv;
		logic signed [15:0] sh;
		logic [2:0]         btn;
		logic [63:0]        stamp;
		logic               last;
	} stick_event_t;

	typedef int unsigned reg_set_t [8];

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [psrf_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [psrf_pkg::CFG_DATA_W-1:0] cfg_data;

	psrf_report_if rpt_ch ();
	psrf_result_if evt_ch ();

	pointing_stick_report_filter #(
		.SCROLL_DIV_V(SCR_DIV_V),
		.SCROLL_DIV_H(SCR_DIV_H)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.report    (rpt_ch),
		.result    (evt_ch)
	);

	// shadow of the block state
	int unsigned     filt_cfg [8];
	psrf_pkg::mode_t mid_mode;
	stick_event_t    expected_events [$];
	int              mismatch_count;
	int              send_idle;
	int              recv_idle;
	int              quiet_cycles;

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------- prediction ----------------

	function automatic int apply_deadzone(input int d);
		int dz;
		dz = int'(filt_cfg[psrf_pkg::CFG_DEADZONE]);
		if (d > dz) return d - dz;
		if (d < -dz) return d + dz;
		return 0;
	endfunction

	function automatic longint apply_gain(input int d, input int unsigned mult,
		input int unsigned div);
		longint q;
		q = (div == 0) ? 64'sd1 : longint'(div);
		return (longint'(d) * longint'(mult)) / q;
	endfunction

	function automatic logic signed [15:0] clamp16(input longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	task automatic predict_events(input logic signed [15:0] in_x, in_y,
		input logic [2:0] in_btn, input logic [63:0] in_stamp);
		int           dx;
		int           dy;
		logic         released;
		logic [2:0]   btn;
		longint       gx;
		longint       gy;
		stick_event_t ev;
		dx = apply_deadzone(int'(in_x));
		dy = apply_deadzone(int'(in_y));
		released = (in_btn & psrf_pkg::MIDDLE_MASK) == 3'b000;
		if (mid_mode == psrf_pkg::MODE_SCROLLED) begin
			if (released) mid_mode = psrf_pkg::MODE_IDLE;
		end else begin
			if (mid_mode != psrf_pkg::MODE_PRESSED) mid_mode = psrf_pkg::MODE_IDLE;
			if (mid_mode == psrf_pkg::MODE_IDLE && !released) mid_mode = psrf_pkg::MODE_PRESSED;
			if (mid_mode == psrf_pkg::MODE_PRESSED) begin
				if (dx != 0 || dy != 0) mid_mode = psrf_pkg::MODE_SCROLLED;
				if (released) begin
					// middle click ahead of the normal event
					ev = '0;
					ev.mx = dx;
					ev.my = dy;
					ev.btn = psrf_pkg::MIDDLE_MASK;
					ev.stamp = in_stamp;
					expected_events.push_back(ev);
					mid_mode = psrf_pkg::MODE_IDLE;
				end
			end
		end
		btn = in_btn & ~psrf_pkg::MIDDLE_MASK;
		ev = '0;
		ev.stamp = in_stamp;
		ev.last = 1'b1;
		if (mid_mode == psrf_pkg::MODE_SCROLLED) begin
			ev.kind = 1'b1;
			ev.sv = clamp16(apply_gain(dy, filt_cfg[psrf_pkg::CFG_SCR_MULT_V], SCR_DIV_V));
			ev.sh = clamp16(apply_gain(dx, filt_cfg[psrf_pkg::CFG_SCR_MULT_H], SCR_DIV_H));
		end else begin
			gx = apply_gain(dx, filt_cfg[psrf_pkg::CFG_PTR_MULT_X],
				filt_cfg[psrf_pkg::CFG_PTR_DIV_X]);
			gy = apply_gain(dy, filt_cfg[psrf_pkg::CFG_PTR_MULT_Y],
				filt_cfg[psrf_pkg::CFG_PTR_DIV_Y]);
			ev.mx = gx[31:0];
			ev.my = gy[31:0];
			ev.btn = btn;
		end
		expected_events.push_back(ev);
	endtask

	// ---------------- checking ----------------

	task automatic check_field(input string name, input logic [63:0] want, got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_event();
		stick_event_t want;
		if (expected_events.size() == 0) begin
			$error("event with no report pending, stamp 0x%0h", evt_ch.stamp_out);
			mismatch_count++;
		end else begin
			want = expected_events.pop_front();
			check_field("event_kind", want.kind, evt_ch.event_kind);
			check_field("move_x", want.mx, evt_ch.move_x);
			check_field("move_y", want.my, evt_ch.move_y);
			check_field("scroll_v", want.sv, evt_ch.scroll_v);
			check_field("scroll_h", want.sh, evt_ch.scroll_h);
			check_field("button_out", want.btn, evt_ch.button_out);
			check_field("stamp_out", want.stamp, evt_ch.stamp_out);
			check_field("last", want.last, evt_ch.last);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (evt_ch.valid && evt_ch.ready) check_event();
			if (rpt_ch.valid && rpt_ch.ready) begin
				predict_events(rpt_ch.delta_x, rpt_ch.delta_y, rpt_ch.button_bits,
					rpt_ch.stamp);
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			evt_ch.ready <= 1'b0;
		end else begin
			evt_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// no transfer on either channel for too long means a hang
	always @(posedge clk) begin
		if (!arst_n || (rpt_ch.valid && rpt_ch.ready) || (evt_ch.valid && evt_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------- stimulus helpers ----------------

	task automatic send_report(input logic signed [15:0] dx, dy, input logic [2:0] b,
		input logic [63:0] st);
		if (send_idle != 0 && $urandom_range(99) < send_idle) begin
			rpt_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		rpt_ch.valid       <= 1'b1;
		rpt_ch.delta_x     <= dx;
		rpt_ch.delta_y     <= dy;
		rpt_ch.button_bits <= b;
		rpt_ch.stamp       <= st;
		do @(posedge clk); while (!rpt_ch.ready);
	endtask

	task automatic wait_events_done();
		rpt_ch.valid <= 1'b0;
		// let the monitor log the last report transfer before the queue is read
		@(posedge clk);
		while (expected_events.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// block must be idle here
	task automatic set_config(input reg_set_t v);
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= psrf_pkg::CFG_IDX_W'(i);
			cfg_data  <= v[i][psrf_pkg::CFG_DATA_W-1:0];
			case (psrf_pkg::cfg_reg_t'(i))
				psrf_pkg::CFG_DEADZONE, psrf_pkg::CFG_SCR_MULT_V,
				psrf_pkg::CFG_SCR_MULT_H: filt_cfg[i] = v[i] & 32'h7fff;
				psrf_pkg::CFG_SPARE: filt_cfg[i] = v[i] & 32'h1;
				default: filt_cfg[i] = v[i] & 32'hffff;
			endcase
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand_stamp();
		return {$urandom, $urandom};
	endfunction

	function automatic logic signed [15:0] signed_mag(input int m);
		if (m > 32767) m = 32767;
		return 16'($urandom_range(1) ? -m : m);
	endfunction

	function automatic logic signed [15:0] rand_motion();
		int dz;
		dz = int'(filt_cfg[psrf_pkg::CFG_DEADZONE]);
		case ($urandom_range(5))
			0: return 16'sd0;
			1: return signed_mag($urandom_range(0, 8));
			2: return 16'($urandom);
			3: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			4: return signed_mag(dz + $urandom_range(0, 3));
			default: return signed_mag($urandom_range(0, 300));
		endcase
	endfunction

	// inside the deadzone, so the tracker sees no motion
	function automatic logic signed [15:0] rand_still();
		return signed_mag($urandom_range(0, int'(filt_cfg[psrf_pkg::CFG_DEADZONE])));
	endfunction

	function automatic int unsigned rand_gain(input int unsigned maxv);
		case ($urandom_range(4))
			0: return $urandom_range(0, 3);
			1: return $urandom_range(0, 16);
			2: return $urandom_range(0, maxv);
			3: return $urandom_range(0, 600);
			default: return maxv;
		endcase
	endfunction

	task automatic rand_config();
		reg_set_t v;
		case ($urandom_range(7))
			0: v[psrf_pkg::CFG_DEADZONE] = 0;
			1: v[psrf_pkg::CFG_DEADZONE] = 32767;
			2: v[psrf_pkg::CFG_DEADZONE] = $urandom_range(0, 500);
			default: v[psrf_pkg::CFG_DEADZONE] = $urandom_range(0, 12);
		endcase
		v[psrf_pkg::CFG_PTR_MULT_X] = rand_gain(65535);
		v[psrf_pkg::CFG_PTR_MULT_Y] = rand_gain(65535);
		v[psrf_pkg::CFG_PTR_DIV_X]  = rand_gain(65535);
		v[psrf_pkg::CFG_PTR_DIV_Y]  = rand_gain(65535);
		v[psrf_pkg::CFG_SCR_MULT_V] = rand_gain(32767);
		v[psrf_pkg::CFG_SCR_MULT_H] = rand_gain(32767);
		v[psrf_pkg::CFG_SPARE]      = $urandom_range(1);
		set_config(v);
	endtask

	// one gesture, returns how many reports it took
	task automatic send_gesture(output int count);
		logic [1:0] lr;
		int         n;
		count = 0;
		lr = 2'($urandom_range(3));
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				n = $urandom_range(1, 4);
				repeat (n) begin
					send_report(rand_motion(), rand_motion(), {1'b0, 2'($urandom_range(3))},
						rand_stamp());
					count++;
				end
			end
			4, 5: begin
				// middle click: press, hold still, release
				send_report(rand_still(), rand_still(), {1'b1, lr}, rand_stamp());
				n = $urandom_range(0, 2);
				repeat (n) send_report(rand_still(), rand_still(), {1'b1, lr}, rand_stamp());
				if ($urandom_range(3) == 0) begin
					send_report(rand_motion(), rand_motion(), {1'b0, lr}, rand_stamp());
				end else begin
					send_report(rand_still(), rand_still(), {1'b0, lr}, rand_stamp());
				end
				count = n + 2;
			end
			6, 7, 8: begin
				// scroll: press, move with middle held, release
				if ($urandom_range(1)) begin
					send_report(rand_still(), rand_still(), {1'b1, lr}, rand_stamp());
				end else begin
					send_report(rand_motion(), rand_motion(), {1'b1, lr}, rand_stamp());
				end
				n = $urandom_range(1, 5);
				repeat (n) begin
					send_report(rand_motion(), rand_motion(), {1'b1, 2'($urandom_range(3))},
						rand_stamp());
				end
				send_report(rand_motion(), rand_motion(), {1'b0, lr}, rand_stamp());
				count = n + 2;
			end
			default: begin
				n = $urandom_range(1, 3);
				repeat (n) begin
					send_report(16'($urandom), 16'($urandom), 3'($urandom_range(7)),
						rand_stamp());
				end
				count = n;
			end
		endcase
	endtask

	// ---------------- tests ----------------

	task automatic test_pointer_extremes();
		send_report(16'sh7fff, 16'sh8000, 3'b000, 64'h0);
		send_report(16'sh8000, 16'sh7fff, 3'b011, 64'hffff_ffff_ffff_ffff);
		send_report(16'sd0, 16'sd0, 3'b001, 64'h5555_aaaa_5555_aaaa);
		send_report(-16'sd1, 16'sd1, 3'b010, 64'haaaa_5555_aaaa_5555);
		wait_events_done();
	endtask

	task automatic test_middle_click();
		// click with no motion, and release with motion while still pressed
		send_report(16'sd0, 16'sd0, 3'b100, 64'h1);
		send_report(16'sd5, -16'sd5, 3'b000, 64'h2);
		send_report(16'sd0, 16'sd0, 3'b110, 64'h3);
		send_report(16'sd0, 16'sd0, 3'b101, 64'h4);
		send_report(16'sd0, 16'sd0, 3'b001, 64'h5);
		send_report(16'sd0, 16'sd0, 3'b111, 64'h6);
		send_report(16'sd0, 16'sd0, 3'b010, 64'h7);
		wait_events_done();
	endtask

	task automatic test_middle_scroll();
		send_report(16'sd3, -16'sd2, 3'b100, 64'h10);
		send_report(-16'sd7, 16'sd9, 3'b111, 64'h11);
		send_report(16'sd0, 16'sd0, 3'b100, 64'h12);
		send_report(16'sd4, 16'sd4, 3'b000, 64'h13);
		wait_events_done();
	endtask

	task automatic test_gain_extremes();
		reg_set_t v;
		// full gains, zero divisors acting as one, scroll saturation
		v = '{0, 65535, 65535, 0, 0, 32767, 32767, 0};
		set_config(v);
		send_report(16'sh7fff, 16'sh8000, 3'b100, 64'h20);
		send_report(16'sh8000, 16'sh7fff, 3'b100, 64'h21);
		send_report(16'sd100, -16'sd100, 3'b000, 64'h22);
		send_report(16'sh8000, 16'sh7fff, 3'b011, 64'h23);
		wait_events_done();
		// widest deadzone, zero gains, largest divisors
		v = '{32767, 0, 0, 65535, 65535, 0, 0, 1};
		set_config(v);
		send_report(16'sh8000, 16'sh7fff, 3'b100, 64'h24);
		send_report(16'sd0, 16'sd0, 3'b000, 64'h25);
		wait_events_done();
		// negative deltas through a small deadzone and halving pointer gains
		v = '{3, 1, 1, 2, 2, 3, 3, 1};
		set_config(v);
		send_report(-16'sd7, 16'sd7, 3'b001, 64'h26);
		send_report(16'sd3, -16'sd3, 3'b100, 64'h27);
		send_report(-16'sd4, 16'sd0, 3'b100, 64'h28);
		send_report(16'sd0, 16'sd0, 3'b000, 64'h29);
		wait_events_done();
	endtask

	task automatic test_random_gestures();
		int sent;
		int n;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle = 30; recv_idle = 84; end
				1: begin send_idle = 84; recv_idle = 30; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			for (int s = 0; s < 3; s++) begin
				wait_events_done();
				rand_config();
				sent = 0;
				while (sent < RAND_ITEMS) begin
					send_gesture(n);
					sent += n;
					// hold off until the block has emptied
					if ($urandom_range(39) == 0) wait_events_done();
				end
			end
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = psrf_pkg::CFG_DEADZONE;
		cfg_data           = '0;
		rpt_ch.valid       = 1'b0;
		rpt_ch.delta_x     = '0;
		rpt_ch.delta_y     = '0;
		rpt_ch.button_bits = '0;
		rpt_ch.stamp       = '0;
		evt_ch.ready       = 1'b0;
		quiet_cycles       = 0;
		mismatch_count     = 0;
		send_idle          = 30;
		recv_idle          = 84;
		filt_cfg           = '{0, 1, 1, 1, 1, 1, 1, 1};
		mid_mode           = psrf_pkg::MODE_IDLE;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_pointer_extremes();
		test_middle_click();
		test_middle_scroll();
		test_gain_extremes();
		test_random_gestures();

		wait_events_done();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0 && expected_events.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
